>>> hw/rtl/ed2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed2d_pkg
// shared types and constants for the 2d distance block
// ----------------------------------------------------------------------------
package ed2d_pkg;

  // queue between the squaring front and the square-root back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  // queue occupancy flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // queue write and read strobes
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

>>> hw/rtl/ed2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed2d_front
// two-stage front: absolute differences, then exact squares and their sum
// ----------------------------------------------------------------------------
module ed2d_front
  import ed2d_pkg::*;
#(
  parameter int COORD_BITS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  first_x,
  input  logic signed [COORD_BITS-1:0]  first_y,
  input  logic signed [COORD_BITS-1:0]  second_x,
  input  logic signed [COORD_BITS-1:0]  second_y,
  input  q_status_t                     q_status,
  output logic                          push,
  output logic [2*COORD_BITS:0]         sum
);

  localparam int CB = COORD_BITS;

  logic                   diff_valid;
  logic [CB-1:0]          dx;
  logic [CB-1:0]          dy;
  logic                   sq_valid;
  logic [2*CB-1:0]        sq_x;
  logic [2*CB-1:0]        sq_y;
  logic                   advance;
  logic signed [CB:0]     diff_x;
  logic signed [CB:0]     diff_y;
  logic [CB:0]            abs_x;
  logic [CB:0]            abs_y;

  // the whole front moves unless its last beat is blocked by a full queue
  assign advance  = !(sq_valid && q_status.full);
  assign in_stall = !advance;
  assign push     = sq_valid && !q_status.full;

  assign diff_x = {second_x[CB-1], second_x} - {first_x[CB-1], first_x};
  assign diff_y = {second_y[CB-1], second_y} - {first_y[CB-1], first_y};
  assign abs_x  = diff_x[CB] ? (CB+1)'(-diff_x) : (CB+1)'(diff_x);
  assign abs_y  = diff_y[CB] ? (CB+1)'(-diff_y) : (CB+1)'(diff_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      sq_valid   <= 1'b0;
    end else if (advance) begin
      diff_valid <= in_valid;
      sq_valid   <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // magnitude never exceeds 2^CB - 1
      dx   <= abs_x[CB-1:0];
      dy   <= abs_y[CB-1:0];
      sq_x <= (2*CB)'(dx) * (2*CB)'(dx);
      sq_y <= (2*CB)'(dy) * (2*CB)'(dy);
    end
  end

  assign sum = {1'b0, sq_x} + {1'b0, sq_y};

endmodule

>>> hw/rtl/ed2d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed2d_queue
// small fifo that lets the front and the back stall on their own
// ----------------------------------------------------------------------------
module ed2d_queue
  import ed2d_pkg::*;
#(
  parameter int WIDTH = 51
) (
  input  logic             clk,
  input  logic             rst,
  input  q_ctrl_t          ctrl,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data,
  output q_status_t        status
);

  logic [WIDTH-1:0]          mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign status  = '{full:  (count == QUEUE_CNT_BITS'(QUEUE_DEPTH)),
                     empty: (count == '0)};
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/ed2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed2d_back
// pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
module ed2d_back
  import ed2d_pkg::*;
#(
  parameter int COORD_BITS = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  q_status_t             q_status,
  input  logic [2*COORD_BITS:0] sum,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS:0]   span
);

  localparam int RW    = COORD_BITS + 1;
  localparam int RAD_W = 2 * RW;
  localparam int REM_W = RW + 3;

  logic             valid [RW];
  logic [RAD_W-1:0] rad   [RW];
  logic [REM_W-1:0] rem   [RW];
  logic [RW-1:0]    root  [RW];
  logic             advance;

  // stages only hold when the finished result is waiting
  assign advance   = !(valid[RW-1] && out_stall);
  assign pop       = advance && !q_status.empty;
  assign out_valid = valid[RW-1];
  assign span      = root[RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             v_in;
    logic [RAD_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_in    = pop;
      assign rad_in  = {1'b0, sum};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign v_in    = valid[k-1];
      assign rad_in  = rad[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
    end

    // bring down the next two radicand bits and try root*4 + 1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (advance) begin
        valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

endmodule

>>> hw/rtl/euclidean_distance_2d.sv
`timescale 1ns / 1ps
// throughput: one pair per cycle unless a stall holds the flow, one square-root stage per result bit
// the four-entry queue absorbs output stalls while the front keeps squaring
// reset: synchronous, active high; clears all valid flags and queue pointers
// payload registers are not reset and carry no meaning until a beat lands
// ----------------------------------------------------------------------------
// euclidean_distance_2d
// straight-line distance between two fixed-point points, truncated
// ----------------------------------------------------------------------------
module euclidean_distance_2d
  import ed2d_pkg::*;
#(
  parameter int COORD_BITS = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel: one point pair per beat
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  // output channel: one distance per beat
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS:0]          span
);

  localparam int SUM_W = 2 * COORD_BITS + 1;

  // squared distance handed from the front to the queue
  logic [SUM_W-1:0] front_sum;
  // queue head read by the square-root pipeline
  logic [SUM_W-1:0] queue_sum;
  q_status_t        q_status;
  q_ctrl_t          q_ctrl;
  // write strobe from the front, read strobe from the back
  logic             q_push;
  logic             q_pop;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  // front: differences in one stage, squares in the next, sum into the queue
  ed2d_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .q_status (q_status),
    .push     (q_push),
    .sum      (front_sum)
  );

  // decoupling queue; flags come straight from its registered count
  ed2d_queue #(
    .WIDTH (SUM_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_data (front_sum),
    .rd_data (queue_sum),
    .status  (q_status)
  );

  // back: digit-by-digit root, the last stage is the output register
  ed2d_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .sum       (queue_sum),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .span      (span)
  );

endmodule
